// ===== rtl/core/lattice_gas_hex_collision_core_assert.svh =====
// Assertion macros for the lattice gas collision core.
`ifndef LATTICE_GAS_HEX_COLLISION_CORE_ASSERT_SVH
`define LATTICE_GAS_HEX_COLLISION_CORE_ASSERT_SVH
// Same-cycle implication.
`define LGHC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define LGHC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== rtl/core/lghc_pkg.sv =====
// Shared types and constants for the lattice gas collision core.
`default_nettype none
package lghc_pkg;
   localparam int TYPE_W  = 3;
   localparam int DIR_W   = 8;
   localparam int RAND_W  = 32;
   localparam int IDX_W   = 8;
   localparam int RES_W   = 12;
   localparam int unsigned MAX_COUNT_DEF = 255;
   localparam logic [DIR_W-1:0] INLET_FLOOR_RST    = 8'd10;
   localparam logic [DIR_W-1:0] OUTLET_CEILING_RST = 8'd3;
   localparam logic [TYPE_W-1:0] CELL_OTHER  = 3'd0;
   localparam logic [TYPE_W-1:0] CELL_FLUID  = 3'd1;
   localparam logic [TYPE_W-1:0] CELL_INLET  = 3'd2;
   localparam logic [TYPE_W-1:0] CELL_OUTLET = 3'd3;
   localparam logic [TYPE_W-1:0] CELL_WALL   = 3'd4;
   localparam logic [IDX_W-1:0] REG_INLET_FLOOR    = 8'd0;
   localparam logic [IDX_W-1:0] REG_OUTLET_CEILING = 8'd1;
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;
endpackage
`default_nettype wire

// ===== rtl/core/lghc_if.sv =====
// Channel interfaces: input word, result word, register writes.
`default_nettype none
interface lghc_req_if;
   import lghc_pkg::*;
   logic valid;
   logic ready;
   logic [TYPE_W-1:0] cell_type;
   logic [DIR_W-1:0] count_dir0;
   logic [DIR_W-1:0] count_dir1;
   logic [DIR_W-1:0] count_dir2;
   logic [DIR_W-1:0] count_dir3;
   logic [DIR_W-1:0] count_dir4;
   logic [DIR_W-1:0] count_dir5;
   logic [RAND_W-1:0] random_select;
   logic [RAND_W-1:0] random_split;
   modport source(output valid, cell_type, count_dir0, count_dir1, count_dir2, count_dir3,
      count_dir4, count_dir5, random_select, random_split, input ready);
   modport sink(input valid, cell_type, count_dir0, count_dir1, count_dir2, count_dir3,
      count_dir4, count_dir5, random_select, random_split, output ready);
endinterface

interface lghc_rsp_if;
   import lghc_pkg::*;
   logic valid;
   logic ready;
   logic [DIR_W-1:0] out_dir0;
   logic [DIR_W-1:0] out_dir1;
   logic [DIR_W-1:0] out_dir2;
   logic [DIR_W-1:0] out_dir3;
   logic [DIR_W-1:0] out_dir4;
   logic [DIR_W-1:0] out_dir5;
   logic overflow;
   modport source(output valid, out_dir0, out_dir1, out_dir2, out_dir3, out_dir4, out_dir5,
      overflow, input ready);
   modport sink(input valid, out_dir0, out_dir1, out_dir2, out_dir3, out_dir4, out_dir5,
      overflow, output ready);
endinterface

interface lghc_csr_if;
   import lghc_pkg::*;
   logic valid;
   logic ready;
   logic [IDX_W-1:0] index;
   logic [DIR_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lghc_mod.sv =====
// Shared restoring modulo unit, one quotient bit per cycle.
`default_nettype none
module lghc_mod (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [lghc_pkg::RAND_W-1:0] dividend,
   input  wire logic [lghc_pkg::RAND_W-1:0] divisor,
   output lghc_pkg::div_stat_type           stat,
   output logic [lghc_pkg::RAND_W-1:0]      remainder
);
   import lghc_pkg::*;
   localparam int CNT_W = $clog2(RAND_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RAND_W-1:0] dvd_ff, dvd_in;
   logic [RAND_W-1:0] dvs_ff, dvs_in;
   logic [RAND_W-1:0] rem_ff, rem_in;
   logic [RAND_W:0]   rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      rem_sh  = {rem_ff, dvd_ff[RAND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[RAND_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = RAND_W'(rem_sh - {1'b0, dvs_ff});
         end else begin
            rem_in = rem_sh[RAND_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(RAND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// ===== rtl/core/lattice_gas_hex_collision_core.sv =====
// Wall, inlet, outlet and pass-through cells go from accept to ST_FIN, then to the result.
// Fluid cells walk all 2N+1 momentum shifts (N = cell mass, up to 1530), walk them again
// until one is picked, run two modulo passes on the shared divider and a split search of
// up to k+1 steps. One word in flight; req ready only while idle.
// The result register lets the next word enter while a result waits to be taken.
// Reset (synchronous, high) clears control and loads inlet_floor 10, outlet_ceiling 3.
`default_nettype none
`include "lattice_gas_hex_collision_core_assert.svh"
module lattice_gas_hex_collision_core #(
   parameter int unsigned MAX_COUNT = lghc_pkg::MAX_COUNT_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   lghc_req_if.sink   req_chan,
   lghc_rsp_if.source rsp_chan,
   lghc_csr_if.sink   csr_chan
);
   import lghc_pkg::*;

   // result counts above this limit force the pass-through fallback
   localparam int unsigned LIM = (MAX_COUNT > 255) ? 255 : MAX_COUNT;
   localparam logic [RES_W-1:0] LIM_C = RES_W'(LIM);

   localparam int SV_W = 13;  // signed momentum terms
   localparam int N_W  = 11;  // cell mass
   localparam int K_W  = 10;  // spare pairs
   localparam int C_W  = 19;  // sub-variant count
   localparam int T_W  = 20;  // triangular running sum

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_SUM     = 4'd1;
   localparam logic [3:0] ST_LAUNCH1 = 4'd2;
   localparam logic [3:0] ST_MOD1    = 4'd3;
   localparam logic [3:0] ST_PICK    = 4'd4;
   localparam logic [3:0] ST_LAUNCH2 = 4'd5;
   localparam logic [3:0] ST_MOD2    = 4'd6;
   localparam logic [3:0] ST_ROOT    = 4'd7;
   localparam logic [3:0] ST_FIN     = 4'd8;

   logic [3:0]             state_ff, state_in;
   logic [DIR_W-1:0]       d_ff [6];
   logic [DIR_W-1:0]       d_in [6];
   logic [RES_W-1:0]       res_ff [6];
   logic [RES_W-1:0]       res_in [6];
   logic [RAND_W-1:0]      rsel_ff, rsel_in, rsplit_ff, rsplit_in;
   logic [N_W-1:0]         n_ff, n_in;
   logic signed [SV_W-1:0] n1_ff, n1_in, n3_ff, n3_in;
   logic signed [SV_W-1:0] w_ff, w_in, pick_ff, pick_in;
   logic [RAND_W-1:0]      total_ff, total_in, r_ff, r_in;
   logic [K_W-1:0]         kpick_ff, kpick_in;
   logic [C_W-1:0]         cpick_ff, cpick_in;
   logic [K_W-1:0]         s_ff, s_in;
   logic [T_W-1:0]         tri_ff, tri_in;
   logic [DIR_W-1:0]       floor_ff, ceil_ff;
   logic                   rsp_valid_ff;
   logic [DIR_W-1:0]       rsp_dir_ff [6];
   logic                   rsp_over_ff;

   // per-shift variant count, shared by both walks
   logic signed [SV_W-1:0] a_v, c_v;
   logic [SV_W-1:0]        abs_a, abs_w, abs_c;
   logic signed [SV_W+1:0] kfull;
   logic                   k_ok;
   logic [K_W-1:0]         k_v;
   logic [2*K_W-1:0]       prod;
   logic [C_W-1:0]         cnt_v;
   logic                   last_w;

   always_comb begin
      a_v    = n1_ff - w_ff;
      c_v    = n3_ff - w_ff;
      abs_a  = a_v[SV_W-1] ? SV_W'(-a_v) : a_v;
      abs_w  = w_ff[SV_W-1] ? SV_W'(-w_ff) : w_ff;
      abs_c  = c_v[SV_W-1] ? SV_W'(-c_v) : c_v;
      kfull  = $signed({4'b0, n_ff}) - $signed({2'b0, abs_a}) - $signed({2'b0, abs_w})
               - $signed({2'b0, abs_c});
      k_ok   = !kfull[SV_W+1] && !kfull[0];
      k_v    = kfull[K_W:1];
      prod   = (2*K_W)'(k_v + 1'b1) * (2*K_W)'(k_v + 2'd2);
      cnt_v  = k_ok ? prod[C_W:1] : '0;
      last_w = (w_ff == $signed({2'b0, n_ff}));
   end

   // shared modulo unit
   logic              div_start;
   logic [RAND_W-1:0] div_dvd, div_dvs, div_rem;
   div_stat_type      div_stat;

   assign div_start = (state_ff == ST_LAUNCH1) || (state_ff == ST_LAUNCH2);
   assign div_dvd   = (state_ff == ST_LAUNCH1) ? rsel_ff : rsplit_ff;
   assign div_dvs   = (state_ff == ST_LAUNCH1) ? ((total_ff == '0) ? RAND_W'(1) : total_ff)
                                               : RAND_W'(cpick_ff);

   lghc_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .stat      (div_stat),
      .remainder (div_rem)
   );

   // split and final result terms
   logic [RAND_W-1:0]      k1_full;
   logic [K_W-1:0]         k1, k2, k3;
   logic signed [SV_W-1:0] fa, fc;
   logic [RES_W-1:0]       pa, na, pb, nb, pc, nc;
   logic                   over;
   logic                   accept;
   logic [DIR_W-1:0]       v;
   logic signed [SV_W-1:0] n2_t;

   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      k1_full = r_ff - RAND_W'(tri_ff) + RAND_W'(s_ff) - RAND_W'(1);
      k1 = k1_full[K_W-1:0];
      k2 = s_ff - K_W'(1) - k1;
      k3 = kpick_ff - (s_ff - K_W'(1));
      fa = n1_ff - pick_ff;
      fc = n3_ff - pick_ff;
      pa = fa[SV_W-1] ? '0 : RES_W'(fa);
      na = fa[SV_W-1] ? RES_W'(-fa) : '0;
      pb = pick_ff[SV_W-1] ? '0 : RES_W'(pick_ff);
      nb = pick_ff[SV_W-1] ? RES_W'(-pick_ff) : '0;
      pc = fc[SV_W-1] ? '0 : RES_W'(fc);
      nc = fc[SV_W-1] ? RES_W'(-fc) : '0;
      over = 1'b0;
      for (int i = 0; i < 6; i++) begin
         if (res_ff[i] > LIM_C) over = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      d_in      = d_ff;
      res_in    = res_ff;
      rsel_in   = rsel_ff;
      rsplit_in = rsplit_ff;
      n_in      = n_ff;
      n1_in     = n1_ff;
      n3_in     = n3_ff;
      w_in      = w_ff;
      pick_in   = pick_ff;
      total_in  = total_ff;
      r_in      = r_ff;
      kpick_in  = kpick_ff;
      cpick_in  = cpick_ff;
      s_in      = s_ff;
      tri_in    = tri_ff;
      v         = '0;
      n2_t      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               d_in[0] = req_chan.count_dir0;
               d_in[1] = req_chan.count_dir1;
               d_in[2] = req_chan.count_dir2;
               d_in[3] = req_chan.count_dir3;
               d_in[4] = req_chan.count_dir4;
               d_in[5] = req_chan.count_dir5;
               rsel_in   = req_chan.random_select;
               rsplit_in = req_chan.random_split;
               n_in = N_W'(d_in[0]) + N_W'(d_in[1]) + N_W'(d_in[2]) + N_W'(d_in[3])
                      + N_W'(d_in[4]) + N_W'(d_in[5]);
               n2_t  = $signed({5'b0, d_in[0]}) - $signed({5'b0, d_in[3]});
               n1_in = $signed({5'b0, d_in[5]}) - $signed({5'b0, d_in[2]}) + n2_t;
               n3_in = $signed({5'b0, d_in[1]}) - $signed({5'b0, d_in[4]}) + n2_t;
               w_in  = -$signed({2'b0, n_in});
               total_in = '0;
               kpick_in = '0;
               cpick_in = C_W'(1);
               pick_in  = '0;
               for (int i = 0; i < 6; i++) begin
                  v = d_in[(i + 3) % 6];
                  if (req_chan.cell_type == CELL_INLET && v < floor_ff) v = floor_ff;
                  if (req_chan.cell_type == CELL_OUTLET && v > ceil_ff) v = ceil_ff;
                  if (req_chan.cell_type == CELL_INLET || req_chan.cell_type == CELL_OUTLET
                      || req_chan.cell_type == CELL_WALL) begin
                     res_in[i] = RES_W'(v);
                  end else begin
                     res_in[i] = RES_W'(d_in[i]);
                  end
               end
               state_in = (req_chan.cell_type == CELL_FLUID) ? ST_SUM : ST_FIN;
            end
         end
         ST_SUM: begin
            total_in = total_ff + RAND_W'(cnt_v);
            w_in = w_ff + 1'b1;
            if (last_w) begin
               w_in = -$signed({2'b0, n_ff});
               state_in = ST_LAUNCH1;
            end
         end
         ST_LAUNCH1: state_in = ST_MOD1;
         ST_MOD1: begin
            if (div_stat.done) begin
               r_in = div_rem + 1'b1;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            w_in = w_ff + 1'b1;
            if (cnt_v != '0) begin
               pick_in  = w_ff;
               kpick_in = k_v;
               cpick_in = cnt_v;
               if (r_ff <= RAND_W'(cnt_v)) begin
                  state_in = ST_LAUNCH2;
               end else begin
                  r_in = r_ff - RAND_W'(cnt_v);
               end
            end
            if (last_w) state_in = ST_LAUNCH2;
         end
         ST_LAUNCH2: state_in = ST_MOD2;
         ST_MOD2: begin
            if (div_stat.done) begin
               r_in   = div_rem + 1'b1;
               s_in   = K_W'(1);
               tri_in = T_W'(1);
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (RAND_W'(tri_ff) < r_ff) begin
               s_in   = s_ff + 1'b1;
               tri_in = tri_ff + T_W'(s_ff) + T_W'(1);
            end else begin
               res_in[0] = pb + RES_W'(k1);
               res_in[3] = nb + RES_W'(k1);
               res_in[1] = pc + RES_W'(k2);
               res_in[4] = nc + RES_W'(k2);
               res_in[5] = pa + RES_W'(k3);
               res_in[2] = na + RES_W'(k3);
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic load_rsp;
   assign load_rsp = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         floor_ff     <= INLET_FLOOR_RST;
         ceil_ff      <= OUTLET_CEILING_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_chan.valid && csr_chan.index == REG_INLET_FLOOR) floor_ff <= csr_chan.data;
         if (csr_chan.valid && csr_chan.index == REG_OUTLET_CEILING) ceil_ff <= csr_chan.data;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      d_ff      <= d_in;
      res_ff    <= res_in;
      rsel_ff   <= rsel_in;
      rsplit_ff <= rsplit_in;
      n_ff      <= n_in;
      n1_ff     <= n1_in;
      n3_ff     <= n3_in;
      w_ff      <= w_in;
      pick_ff   <= pick_in;
      total_ff  <= total_in;
      r_ff      <= r_in;
      kpick_ff  <= kpick_in;
      cpick_ff  <= cpick_in;
      s_ff      <= s_in;
      tri_ff    <= tri_in;
      if (load_rsp) begin
         for (int i = 0; i < 6; i++) begin
            rsp_dir_ff[i] <= over ? d_ff[i] : res_ff[i][DIR_W-1:0];
         end
         rsp_over_ff <= over;
      end
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign csr_chan.ready    = 1'b1;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_dir0 = rsp_dir_ff[0];
   assign rsp_chan.out_dir1 = rsp_dir_ff[1];
   assign rsp_chan.out_dir2 = rsp_dir_ff[2];
   assign rsp_chan.out_dir3 = rsp_dir_ff[3];
   assign rsp_chan.out_dir4 = rsp_dir_ff[4];
   assign rsp_chan.out_dir5 = rsp_dir_ff[5];
   assign rsp_chan.overflow = rsp_over_ff;

   `LGHC_ASSERT_IMPLIES(a_ready_idle, clock, reset, req_chan.ready, state_ff == ST_IDLE)
   `LGHC_ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != ST_IDLE)
   `LGHC_ASSERT_IMPLIES(a_root_s, clock, reset, state_ff == ST_ROOT, s_ff != '0)
   `LGHC_ASSERT_IMPLIES(a_div_free, clock, reset, div_start, !div_stat.busy)
endmodule
`default_nettype wire
